// ===== design/bech32_checksum_codec_defines.svh =====
// Assertion macros shared by the Bech32 checksum codec RTL.
// Uses the clk and rst_n names of the including module.
`ifndef BECH32_CHECKSUM_CODEC_DEFINES_SVH
`define BECH32_CHECKSUM_CODEC_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset
`define B32_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bech32 codec check failed");
// Check that a condition is followed by a property in the next cycle
`define B32_IMPLY_NEXT(lbl, cond, nxt_prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt_prop)) \
    else $error("bech32 codec sequencing check failed");
`else
`define B32_CHECK(lbl, prop)
`define B32_IMPLY_NEXT(lbl, cond, nxt_prop)
`endif
`endif

// ===== design/b32cc_pkg.sv =====
// Shared types, constants and table functions of the Bech32 checksum codec.
// No dependencies; imported by the polymod unit and the top level of the codec.
`default_nettype none

package b32cc_pkg;

  // HRP storage limits
  localparam int MAX_HRP = 83;
  localparam int HRP_AW  = $clog2(MAX_HRP);
  localparam int LEN_W   = $clog2(MAX_HRP + 1);
  localparam int ACC_W   = 30;

  // Input commands
  typedef enum logic [1:0] {
    CMD_HRP  = 2'd0,
    CMD_SEP  = 2'd1,
    CMD_DATA = 2'd2,
    CMD_FIN  = 2'd3
  } cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_SYMBOL = 2'd2
  } kind_t;

  // Status codes
  typedef enum logic [3:0] {
    STS_OK        = 4'd0,
    STS_BAD_HRP   = 4'd1,
    STS_EMPTY_HRP = 4'd2,
    STS_HRP_OVF   = 4'd3,
    STS_BAD_CHAR  = 4'd4,
    STS_RANGE     = 4'd5,
    STS_SHORT     = 4'd6,
    STS_MISMATCH  = 4'd7,
    STS_SEQ       = 4'd8
  } sts_t;

  // Polymod unit operations
  typedef enum logic [2:0] {
    PM_HOLD  = 3'd0,
    PM_INIT  = 3'd1,
    PM_FOLD  = 3'd2,
    PM_XOR1  = 3'd3,
    PM_SHIFT = 3'd4
  } pm_op_t;

  typedef struct packed {
    pm_op_t     op;
    logic [4:0] sym;
  } pm_ctl_t;

  // BCH generator terms
  localparam logic [ACC_W-1:0] GEN [0:4] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  // Bech32 character set, symbol order
  localparam logic [7:0] CHARSET [0:31] = '{
    8'h71, 8'h70, 8'h7a, 8'h72, 8'h79, 8'h39, 8'h78, 8'h38,
    8'h67, 8'h66, 8'h32, 8'h74, 8'h76, 8'h64, 8'h77, 8'h30,
    8'h73, 8'h33, 8'h6a, 8'h6e, 8'h35, 8'h34, 8'h6b, 8'h68,
    8'h63, 8'h65, 8'h36, 8'h6d, 8'h75, 8'h61, 8'h37, 8'h6c
  };

  localparam logic [7:0] SEP_CHAR = 8'h31;

  function automatic logic [7:0] sym_to_char(input logic [4:0] sym);
    return CHARSET[sym];
  endfunction

  // Reverse lookup: {hit, symbol}
  function automatic logic [5:0] char_to_sym(input logic [7:0] c);
    logic [5:0] res;
    res = '0;
    for (int i = 0; i < 32; i++) begin
      if (CHARSET[i] == c) begin
        res = {1'b1, 5'(i)};
      end
    end
    return res;
  endfunction

  // Fold A-Z down to a-z
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

endpackage

`default_nettype wire

// ===== design/b32cc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the stored HRP characters.
`default_nettype none

module b32cc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 83,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/b32cc_polymod.sv =====
// Shared polymod unit: 30-bit checksum accumulator and its one-step fold.
// Depends on b32cc_pkg for the generator terms and the control struct.
`default_nettype none

module b32cc_polymod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  b32cc_pkg::pm_ctl_t         ctl,
  output logic [b32cc_pkg::ACC_W-1:0] acc
);

  import b32cc_pkg::*;

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [ACC_W-1:0] fold_c;
  logic [4:0]       top_c;

  // One polymod step on the current accumulator
  always_comb begin
    top_c  = acc_r[ACC_W-1 -: 5];
    fold_c = {acc_r[ACC_W-6:0], ctl.sym};
    for (int i = 0; i < 5; i++) begin
      if (top_c[i]) begin
        fold_c = fold_c ^ GEN[i];
      end
    end
  end

  // Select the accumulator update
  always_comb begin
    unique case (ctl.op)
      PM_HOLD:  acc_nxt = acc_r;
      PM_INIT:  acc_nxt = ACC_W'(1);
      PM_FOLD:  acc_nxt = fold_c;
      PM_XOR1:  acc_nxt = acc_r ^ ACC_W'(1);
      PM_SHIFT: acc_nxt = {acc_r[ACC_W-6:0], 5'd0};
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= ACC_W'(1);
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== design/bech32_checksum_codec.sv =====
// Bech32 encoder/decoder top level: sequencer, HRP store, delay line, output register.
// Depends on b32cc_pkg, b32cc_ram, b32cc_polymod and the assertion macro header.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------------
//   in_      | in  | in_tvalid/tready   | tdata: value; tuser: command
//   out_     | out | out_tvalid/tready  | tdata: char,symbol,status; tuser: kind; tlast
//   cfg_     | in  | cfg_wen            | cfg_wdata: mode
//
// HRP characters and data words may stream back to back while the output slot is free.
// A separator walks the HRP store twice through its one read port, folding the high
// bits of each character, a zero and then the low bits, before the '1' word is loaded.
// An encode finish takes six folds and a final xor, then loads one checksum word per
// cycle while the output slot is free, the last of them with tlast set.
// Reset is synchronous, active low; the HRP store and delay line need no clearing.
// A stalled output word holds the input: no word is accepted until the slot frees.
`default_nettype none

module bech32_checksum_codec (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] value
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_char, [12:8] out_symbol, [16:13] status
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  // mode register
  input  logic        cfg_wen,
  input  logic        cfg_wdata
);

  import b32cc_pkg::*;

  `include "bech32_checksum_codec_defines.svh"

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_HI     = 8'b0000_0010,
    ST_ZERO   = 8'b0000_0100,
    ST_LO     = 8'b0000_1000,
    ST_SEPOUT = 8'b0001_0000,
    ST_FFOLD  = 8'b0010_0000,
    ST_FXOR   = 8'b0100_0000,
    ST_FEMIT  = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic             mode_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  sts_t             err_r, err_nxt;
  logic             indata_r, indata_nxt;
  logic [2:0]       dcnt_r, dcnt_nxt;
  logic [4:0]       dly_r [0:5];

  logic             out_vld_r;
  kind_t            out_kind_r;
  logic [7:0]       out_char_r;
  logic [4:0]       out_sym_r;
  sts_t             out_sts_r;
  logic             out_last_r;

  logic             slot_free;
  logic             in_acc;
  cmd_t             cmd;
  logic [7:0]       val;
  logic [7:0]       hrp_c;
  logic [5:0]       dec_c;
  logic [2:0]       dcnt_inc;

  logic             ld;
  kind_t            ld_kind;
  logic [7:0]       ld_char;
  logic [4:0]       ld_sym;
  sts_t             ld_sts;
  logic             ld_last;
  logic             clr;
  sts_t             err_c;
  logic             dly_shift;

  logic             ram_we;
  logic [HRP_AW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  pm_ctl_t          pm_ctl;
  logic [ACC_W-1:0] acc;

  b32cc_ram #(.WIDTH(8), .DEPTH(MAX_HRP)) u_hrp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[HRP_AW-1:0]),
    .wdata (hrp_c),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  b32cc_polymod u_polymod (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pm_ctl),
    .acc   (acc)
  );

  // Handshake and field decode
  assign slot_free = !out_vld_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign val       = in_tdata;
  assign hrp_c     = mode_r ? to_lower(val) : val;
  assign dec_c     = char_to_sym(to_lower(val));
  assign dcnt_inc  = (dcnt_r == 3'd7) ? dcnt_r : dcnt_r + 3'd1;

  // Walk address for the HRP store
  assign ram_raddr = ((state_r == ST_HI || state_r == ST_LO) && idx_r < len_r)
                     ? idx_r[HRP_AW-1:0] : '0;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    indata_nxt = indata_r;
    dcnt_nxt   = dcnt_r;
    pm_ctl.op  = PM_HOLD;
    pm_ctl.sym = '0;
    ld         = 1'b0;
    ld_kind    = KIND_STATUS;
    ld_char    = '0;
    ld_sym     = '0;
    ld_sts     = STS_OK;
    ld_last    = 1'b1;
    clr        = 1'b0;
    err_c      = STS_OK;
    dly_shift  = 1'b0;
    ram_we     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ld = 1'b1;
          if (err_r != STS_OK) begin
            // sticky error: report only, finish clears
            ld_sts = err_r;
            clr    = (cmd == CMD_FIN);
          end else begin
            unique case (cmd)
              CMD_HRP: begin
                if (indata_r) begin
                  err_c = STS_SEQ;
                end else if (val < 8'd33 || val > 8'd126) begin
                  err_c = STS_BAD_HRP;
                end else if (len_r >= LEN_W'(MAX_HRP)) begin
                  err_c = STS_HRP_OVF;
                end else begin
                  ram_we  = 1'b1;
                  len_nxt = len_r + LEN_W'(1);
                  ld_kind = KIND_TEXT;
                  ld_char = hrp_c;
                end
              end
              CMD_SEP: begin
                if (indata_r) begin
                  err_c = STS_SEQ;
                end else if (len_r == '0) begin
                  err_c = STS_EMPTY_HRP;
                end else begin
                  // start the HRP walk; address 0 is read this cycle
                  ld        = 1'b0;
                  idx_nxt   = LEN_W'(1);
                  state_nxt = ST_HI;
                end
              end
              CMD_DATA: begin
                if (!indata_r) begin
                  err_c = STS_SEQ;
                end else if (!mode_r) begin
                  if (val > 8'd31) begin
                    err_c = STS_RANGE;
                  end else begin
                    pm_ctl.op  = PM_FOLD;
                    pm_ctl.sym = val[4:0];
                    dcnt_nxt   = dcnt_inc;
                    ld_kind    = KIND_TEXT;
                    ld_char    = sym_to_char(val[4:0]);
                  end
                end else begin
                  if (!dec_c[5]) begin
                    err_c = STS_BAD_CHAR;
                  end else begin
                    pm_ctl.op  = PM_FOLD;
                    pm_ctl.sym = dec_c[4:0];
                    dly_shift  = 1'b1;
                    dcnt_nxt   = dcnt_inc;
                    if (dcnt_r >= 3'd6) begin
                      ld_kind = KIND_SYMBOL;
                      ld_sym  = dly_r[5];
                    end
                  end
                end
              end
              CMD_FIN: begin
                if (!indata_r) begin
                  ld_sts = STS_SEQ;
                  clr    = 1'b1;
                end else if (!mode_r) begin
                  ld        = 1'b0;
                  cnt_nxt   = '0;
                  state_nxt = ST_FFOLD;
                end else begin
                  priority if (dcnt_r < 3'd6) begin
                    ld_sts = STS_SHORT;
                  end else if (acc != ACC_W'(1)) begin
                    ld_sts = STS_MISMATCH;
                  end else begin
                    ld_sts = STS_OK;
                  end
                  clr = 1'b1;
                end
              end
            endcase
            // record a new error
            if (err_c != STS_OK) begin
              err_nxt = err_c;
              ld_kind = KIND_STATUS;
              ld_char = '0;
              ld_sym  = '0;
              ld_sts  = err_c;
            end
          end
        end
      end
      ST_HI: begin
        pm_ctl.op  = PM_FOLD;
        pm_ctl.sym = {2'b00, ram_rdata[7:5]};
        if (idx_r < len_r) begin
          idx_nxt = idx_r + LEN_W'(1);
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        // fold the zero separator while address 0 is read again
        pm_ctl.op = PM_FOLD;
        idx_nxt   = LEN_W'(1);
        state_nxt = ST_LO;
      end
      ST_LO: begin
        pm_ctl.op  = PM_FOLD;
        pm_ctl.sym = ram_rdata[4:0];
        if (idx_r < len_r) begin
          idx_nxt = idx_r + LEN_W'(1);
        end else begin
          state_nxt = ST_SEPOUT;
        end
      end
      ST_SEPOUT: begin
        if (slot_free) begin
          ld         = 1'b1;
          ld_kind    = KIND_TEXT;
          ld_char    = SEP_CHAR;
          indata_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_FFOLD: begin
        pm_ctl.op = PM_FOLD;
        cnt_nxt   = cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          state_nxt = ST_FXOR;
        end
      end
      ST_FXOR: begin
        pm_ctl.op = PM_XOR1;
        cnt_nxt   = '0;
        state_nxt = ST_FEMIT;
      end
      ST_FEMIT: begin
        if (slot_free) begin
          ld      = 1'b1;
          ld_kind = KIND_TEXT;
          ld_char = sym_to_char(acc[ACC_W-1 -: 5]);
          ld_last = (cnt_r == 3'd5);
          if (cnt_r == 3'd5) begin
            clr       = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            pm_ctl.op = PM_SHIFT;
            cnt_nxt   = cnt_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // end of message
    if (clr) begin
      len_nxt    = '0;
      err_nxt    = STS_OK;
      indata_nxt = 1'b0;
      dcnt_nxt   = '0;
      pm_ctl.op  = PM_INIT;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= 1'b0;
      len_r     <= '0;
      err_r     <= STS_OK;
      indata_r  <= 1'b0;
      dcnt_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      err_r    <= err_nxt;
      indata_r <= indata_nxt;
      dcnt_r   <= dcnt_nxt;
      if (cfg_wen) begin
        mode_r <= cfg_wdata;
      end
      if (ld) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Counters, delay line and output payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    if (dly_shift) begin
      dly_r[0] <= dec_c[4:0];
      for (int i = 1; i < 6; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
    if (ld) begin
      out_kind_r <= ld_kind;
      out_char_r <= ld_char;
      out_sym_r  <= ld_sym;
      out_sts_r  <= ld_sts;
      out_last_r <= ld_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_sts_r, out_sym_r, out_char_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Checks
  `B32_CHECK(a_len_max, len_r <= LEN_W'(MAX_HRP))
  `B32_CHECK(a_data_has_hrp, indata_r |-> (len_r != '0))
  `B32_IMPLY_NEXT(a_err_sticky, (err_r != STS_OK) && !(in_acc && cmd == CMD_FIN), err_r == $past(err_r))
  `B32_CHECK(a_emit_clean, (state_r == ST_FEMIT) |-> (err_r == STS_OK))

endmodule

`default_nettype wire
